/* rtl/frdt_pkg.sv */
// Shared types, constants and codes of the foveated density texel block.
package frdt_pkg;

	// Default shading-rate texel size in pixels
	localparam int TEXEL_WIDTH_DEF  = 16;
	localparam int TEXEL_HEIGHT_DEF = 16;

	localparam int REG_IDX_W  = 3;
	localparam int REG_DATA_W = 15;

	// Setup divider: numerator bits retired one per cycle
	localparam int DIV_NUM_W = 40;
	localparam int DIV_DEN_W = 16;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TARGET_WIDTH,
		REG_TARGET_HEIGHT,
		REG_MIN_RADIUS_PCT,
		REG_STRENGTH,
		REG_REGION_X,
		REG_REGION_Y,
		REG_REGION_WIDTH,
		REG_REGION_HEIGHT
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_SX,
		ST_SY,
		ST_MINR,
		ST_OUTER,
		ST_OFFX,
		ST_OFFY,
		ST_IDLE
	} setup_state_t;

	// Per-configuration values derived by the setup unit
	typedef struct packed {
		logic        ready;
		logic [14:0] sx;
		logic [14:0] sy;
		logic [14:0] tw;
		logic [14:0] th;
		logic [14:0] rw;
		logic [14:0] rh;
		logic [28:0] offx;
		logic [28:0] offy;
		logic [29:0] minr;
		logic [34:0] outer;
	} cfg_derived_t;

	// One classified texel waiting for the back end
	typedef struct packed {
		logic        outside;
		logic [13:0] col;
		logic [13:0] row;
		logic [15:0] fxp;
		logic [16:0] fyp;
	} q_item_t;

endpackage

/* rtl/frdt_in_if.sv */
// Texel request channel: coordinate and eye focus.
interface frdt_in_if;
	logic               valid;
	logic               ready;
	logic [13:0]        texel_col;
	logic [13:0]        texel_row;
	logic signed [15:0] focus_x;
	logic signed [15:0] focus_y;

	modport source (output valid, output texel_col, output texel_row,
		output focus_x, output focus_y, input ready);
	modport sink (input valid, input texel_col, input texel_row,
		input focus_x, input focus_y, output ready);
endinterface

/* rtl/frdt_out_if.sv */
// Density result channel.
interface frdt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] density;
	logic       outside_map;

	modport source (output valid, output density, output outside_map, input ready);
	modport sink (input valid, input density, input outside_map, output ready);
endinterface

/* rtl/frdt_setup.sv */
// Configuration registers and the iterative setup pass that derives per-map constants.
module frdt_setup import frdt_pkg::*; #(
	parameter int TEXEL_WIDTH  = TEXEL_WIDTH_DEF,
	parameter int TEXEL_HEIGHT = TEXEL_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  write_en,
	input  logic [REG_IDX_W-1:0]  reg_index,
	input  logic [REG_DATA_W-1:0] write_data,
	output cfg_derived_t          drv
);

	logic [14:0] tw_raw_q, th_raw_q, rwid_q, rht_q;
	logic [13:0] rx_q, ry_q;
	logic [6:0]  pct_q, st_q;

	logic [14:0] sx_q, sy_q;
	logic [29:0] minr_q;
	logic [34:0] outer_q;
	logic [28:0] offx_q, offy_q;

	setup_state_t state_q, state_n;

	logic                 div_run_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [DIV_DEN_W-1:0] div_rem_q, div_den_q;
	logic [DIV_NUM_W-1:0] div_nq_q;
	logic [DIV_DEN_W:0]   div_cand;
	logic                 div_ge;
	logic [DIV_NUM_W-1:0] div_nq_n;
	logic                 div_done;

	logic [DIV_NUM_W-1:0] op_num;
	logic [DIV_DEN_W-1:0] op_den;

	logic [14:0] tw1, th1, rw, rh, min_s;
	logic [13:0] rx, ry;
	logic [6:0]  pct_c, st_c;
	logic [29:0] mr;
	logic        region_on;

	// Clamp and substitute register values
	assign tw1       = (tw_raw_q == '0) ? 15'd1 : tw_raw_q;
	assign th1       = (th_raw_q == '0) ? 15'd1 : th_raw_q;
	assign region_on = |{rx_q, ry_q, rwid_q, rht_q};
	assign rx        = region_on ? rx_q : '0;
	assign ry        = region_on ? ry_q : '0;
	assign rw        = (region_on && rwid_q != '0) ? rwid_q : tw1;
	assign rh        = (region_on && rht_q != '0) ? rht_q : th1;
	assign pct_c     = (pct_q == '0) ? 7'd1 : ((pct_q > 7'd100) ? 7'd100 : pct_q);
	assign st_c      = (st_q == '0) ? 7'd1 : ((st_q > 7'd100) ? 7'd100 : st_q);
	assign min_s     = (sx_q < sy_q) ? sx_q : sy_q;
	assign mr        = {min_s, 15'b0};

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_raw_q <= 15'd1920;
			th_raw_q <= 15'd1080;
			pct_q    <= 7'd20;
			st_q     <= 7'd10;
			rx_q     <= '0;
			ry_q     <= '0;
			rwid_q   <= '0;
			rht_q    <= '0;
		end else if (write_en) begin
			case (reg_idx_t'(reg_index))
				REG_TARGET_WIDTH:   tw_raw_q <= write_data;
				REG_TARGET_HEIGHT:  th_raw_q <= write_data;
				REG_MIN_RADIUS_PCT: pct_q    <= write_data[6:0];
				REG_STRENGTH:       st_q     <= write_data[6:0];
				REG_REGION_X:       rx_q     <= write_data[13:0];
				REG_REGION_Y:       ry_q     <= write_data[13:0];
				REG_REGION_WIDTH:   rwid_q   <= write_data;
				REG_REGION_HEIGHT:  rht_q    <= write_data;
				default: ;
			endcase
		end
	end

	// One quotient bit per cycle
	assign div_cand = {div_rem_q, div_nq_q[DIV_NUM_W-1]};
	assign div_ge   = div_cand >= {1'b0, div_den_q};
	assign div_nq_n = {div_nq_q[DIV_NUM_W-2:0], div_ge};
	assign div_done = div_run_q && (div_cnt_q == DIV_CNT_W'(DIV_NUM_W - 1));

	// Next state
	always_comb begin
		state_n = state_q;
		if (write_en) begin
			state_n = ST_SX;
		end else if (div_done) begin
			case (state_q)
				ST_SX:    state_n = ST_SY;
				ST_SY:    state_n = ST_MINR;
				ST_MINR:  state_n = ST_OUTER;
				ST_OUTER: state_n = ST_OFFX;
				ST_OFFX:  state_n = ST_OFFY;
				default:  state_n = ST_IDLE;
			endcase
		end
	end

	// Divider operands for the current step
	always_comb begin
		op_num = '0;
		op_den = 16'd1;
		case (state_q)
			ST_SX: begin
				op_num = DIV_NUM_W'({tw_raw_q, 1'b0}) + DIV_NUM_W'(TEXEL_WIDTH);
				op_den = DIV_DEN_W'(2 * TEXEL_WIDTH);
			end
			ST_SY: begin
				op_num = DIV_NUM_W'({th_raw_q, 1'b0}) + DIV_NUM_W'(TEXEL_HEIGHT);
				op_den = DIV_DEN_W'(2 * TEXEL_HEIGHT);
			end
			ST_MINR: begin
				op_num = DIV_NUM_W'(pct_c) * DIV_NUM_W'(mr);
				op_den = 16'd100;
			end
			ST_OUTER: begin
				op_num = DIV_NUM_W'(mr - minr_q) * DIV_NUM_W'(10);
				op_den = DIV_DEN_W'(st_c);
			end
			ST_OFFX: begin
				op_num = DIV_NUM_W'(rx) * DIV_NUM_W'(sx_q);
				op_den = DIV_DEN_W'(tw1);
			end
			ST_OFFY: begin
				op_num = DIV_NUM_W'(ry) * DIV_NUM_W'(sy_q);
				op_den = DIV_DEN_W'(th1);
			end
			default: ;
		endcase
	end

	// Sequencer and divider state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SX;
			div_run_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_n;
			if (write_en || div_done) begin
				div_run_q <= 1'b0;
			end else if (state_q != ST_IDLE && !div_run_q) begin
				div_run_q <= 1'b1;
				div_cnt_q <= '0;
			end else if (div_run_q) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
		end
	end

	// Load and advance the divider datapath
	always_ff @(posedge clk) begin
		if (!div_run_q) begin
			div_rem_q <= '0;
			div_nq_q  <= op_num;
			div_den_q <= op_den;
		end else begin
			div_rem_q <= div_ge ? DIV_DEN_W'(div_cand - {1'b0, div_den_q})
				: div_cand[DIV_DEN_W-1:0];
			div_nq_q  <= div_nq_n;
		end
	end

	// Capture each result as its division retires
	always_ff @(posedge clk) begin
		if (div_done) begin
			case (state_q)
				ST_SX:    sx_q <= (div_nq_n == '0) ? 15'd1 : div_nq_n[14:0];
				ST_SY:    sy_q <= (div_nq_n == '0) ? 15'd1 : div_nq_n[14:0];
				ST_MINR:  minr_q <= div_nq_n[29:0];
				ST_OUTER: outer_q <= (div_nq_n < DIV_NUM_W'(65536)) ? 35'd65536
					: div_nq_n[34:0];
				ST_OFFX:  offx_q <= div_nq_n[28:0];
				ST_OFFY:  offy_q <= div_nq_n[28:0];
				default: ;
			endcase
		end
	end

	// Derived values out
	always_comb begin
		drv.ready = (state_q == ST_IDLE);
		drv.sx    = sx_q;
		drv.sy    = sy_q;
		drv.tw    = tw1;
		drv.th    = th1;
		drv.rw    = rw;
		drv.rh    = rh;
		drv.offx  = offx_q;
		drv.offy  = offy_q;
		drv.minr  = minr_q;
		drv.outer = outer_q;
	end

endmodule

/* rtl/frdt_front.sv */
// Front end: accept texels, flag those outside the map, and queue them.
module frdt_front import frdt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	frdt_in_if.sink      texel,
	input  cfg_derived_t drv,
	output q_item_t      item,
	output logic         item_valid,
	input  logic         item_pop
);

	q_item_t                mem [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;
	logic                   push;
	q_item_t                cls;

	assign texel.ready = drv.ready && (count_q < (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
	assign push        = texel.valid && texel.ready;

	// Classify and bias the focus into unsigned offsets
	always_comb begin
		cls.outside = ({1'b0, texel.texel_col} >= drv.sx) || ({1'b0, texel.texel_row} >= drv.sy);
		cls.col     = texel.texel_col;
		cls.row     = texel.texel_row;
		cls.fxp     = {~texel.focus_x[15], texel.focus_x[14:0]};
		cls.fyp     = 17'd65536 - {1'b0, ~texel.focus_y[15], texel.focus_y[14:0]};
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= cls;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (item_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !item_pop) begin
				count_q <= count_q + 1'b1;
			end else if (item_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign item       = mem[rd_ptr_q];
	assign item_valid = (count_q != '0);

endmodule

/* rtl/frdt_pdiv.sv */
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
module frdt_pdiv #(
	parameter int DW = 15,
	parameter int QW = 31,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  logic [DW-1:0] rem0,
	input  logic [QW-1:0] nlow,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] sb,
	output logic          out_v,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] sb_o
);

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] nq_s  [QW];
	logic [DW-1:0] den_s [QW];
	logic [SW-1:0] sb_s  [QW];
	logic          v_s   [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DW-1:0] r_in, d_in;
		logic [QW-1:0] n_in;
		logic [SW-1:0] b_in;
		logic          v_in;
		logic [DW:0]   cand;
		logic          ge;

		if (i == 0) begin : g_first
			assign r_in = rem0;
			assign n_in = nlow;
			assign d_in = den;
			assign b_in = sb;
			assign v_in = in_v;
		end else begin : g_next
			assign r_in = rem_s[i-1];
			assign n_in = nq_s[i-1];
			assign d_in = den_s[i-1];
			assign b_in = sb_s[i-1];
			assign v_in = v_s[i-1];
		end

		// Shift in one numerator bit, subtract when it fits
		assign cand = {r_in, n_in[QW-1]};
		assign ge   = cand >= {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? DW'(cand - {1'b0, d_in}) : cand[DW-1:0];
				nq_s[i]  <= {n_in[QW-2:0], ge};
				den_s[i] <= d_in;
				sb_s[i]  <= b_in;
			end
		end
	end

	assign out_v = v_s[QW-1];
	assign quo   = nq_s[QW-1];
	assign sb_o  = sb_s[QW-1];

endmodule

/* rtl/frdt_isqrt.sv */
// Pipelined integer square root of a 63-bit value, one result bit per stage.
module frdt_isqrt #(
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  logic [62:0]   val,
	input  logic [SW-1:0] sb,
	output logic          out_v,
	output logic [31:0]   root,
	output logic [SW-1:0] sb_o
);

	localparam int STAGES = 32;

	logic [62:0]   v_s   [STAGES];
	logic [63:0]   r_s   [STAGES];
	logic [SW-1:0] sb_s  [STAGES];
	logic          vld_s [STAGES];

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam logic [63:0] BIT = 64'(1) << (2 * (STAGES - 1 - i));
		logic [62:0]   v_in;
		logic [63:0]   r_in, t;
		logic [SW-1:0] b_in;
		logic          vl_in, ge;

		if (i == 0) begin : g_first
			assign v_in  = val;
			assign r_in  = '0;
			assign b_in  = sb;
			assign vl_in = in_v;
		end else begin : g_next
			assign v_in  = v_s[i-1];
			assign r_in  = r_s[i-1];
			assign b_in  = sb_s[i-1];
			assign vl_in = vld_s[i-1];
		end

		// Try the next root bit
		assign t  = r_in + BIT;
		assign ge = {1'b0, v_in} >= t;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vl_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[i]  <= ge ? 63'({1'b0, v_in} - t) : v_in;
				r_s[i]  <= ge ? ((r_in >> 1) + BIT) : (r_in >> 1);
				sb_s[i] <= b_in;
			end
		end
	end

	assign out_v = vld_s[STAGES-1];
	assign root  = r_s[STAGES-1][31:0];
	assign sb_o  = sb_s[STAGES-1];

endmodule

/* rtl/frdt_back.sv */
// Back end: focus center, scaled offsets, distance and density, in lockstep stages.
module frdt_back import frdt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_derived_t drv,
	input  q_item_t      item,
	input  logic         item_valid,
	output logic         item_pop,
	frdt_out_if.source   result
);

	logic adv;

	logic        v_s1, out_s1;
	logic [13:0] col_s1, row_s1;
	logic [31:0] m1x_s1, m1y_s1;

	logic        v_s2, out_s2;
	logic [13:0] col_s2, row_s2;
	logic [46:0] nx_s2, ny_s2;

	logic        cx_v, cy_v;
	logic [30:0] qx, qy;
	logic [14:0] cx_sb;
	logic [13:0] cy_sb;
	logic [31:0] cx, cy;

	logic        v_s3, out_s3;
	logic [31:0] ax_s3, ay_s3;

	logic        v_s4, out_s4;
	logic [46:0] px_s4, py_s4;
	logic        satx, saty;

	logic        ox_v, oy_v;
	logic [30:0] qox, qoy, ox, oy;
	logic [1:0]  ox_sb;
	logic        oy_sb;

	logic        v_s5, out_s5;
	logic [61:0] sqx_s5, sqy_s5;

	logic        v_s6, out_s6;
	logic [62:0] sum_s6;

	logic        rt_v, rt_out;
	logic [31:0] len, excess;
	logic [39:0] e_w;

	logic        v_s7, out_s7, sat_s7;
	logic [39:0] e_s7;

	logic        dn_v;
	logic [7:0]  qd;
	logic [1:0]  dn_sb;

	logic        ov_q, oout_q;
	logic [7:0]  odens_q;

	// The whole chain moves while the output register is free
	assign adv      = !ov_q || result.ready;
	assign item_pop = adv && item_valid;

	// Stage 1: map size times biased focus
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			ov_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_pop;
			v_s2 <= v_s1;
			v_s3 <= cx_v && cy_v;
			v_s4 <= v_s3;
			v_s5 <= ox_v && oy_v;
			v_s6 <= v_s5;
			v_s7 <= rt_v;
			ov_q <= dn_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s1 <= item.outside;
			col_s1 <= item.col;
			row_s1 <= item.row;
			m1x_s1 <= 32'(drv.sx) * 32'(item.fxp);
			m1y_s1 <= 32'(drv.sy) * 32'(item.fyp);
		end
	end

	// Stage 2: times region size
	always_ff @(posedge clk) begin
		if (adv) begin
			out_s2 <= out_s1;
			col_s2 <= col_s1;
			row_s2 <= row_s1;
			nx_s2  <= 47'(m1x_s1) * 47'(drv.rw);
			ny_s2  <= 47'(m1y_s1) * 47'(drv.rh);
		end
	end

	// Divide by target size to get the center in texels
	frdt_pdiv #(.DW(15), .QW(31), .SW(15)) u_div_cx (
		.clk, .arst_n, .en(adv), .in_v(v_s2),
		.rem0('0), .nlow(nx_s2[46:16]), .den(drv.tw), .sb({out_s2, col_s2}),
		.out_v(cx_v), .quo(qx), .sb_o(cx_sb)
	);

	frdt_pdiv #(.DW(15), .QW(31), .SW(14)) u_div_cy (
		.clk, .arst_n, .en(adv), .in_v(v_s2),
		.rem0('0), .nlow(ny_s2[46:16]), .den(drv.th), .sb(row_s2),
		.out_v(cy_v), .quo(qy), .sb_o(cy_sb)
	);

	// Stage 3: add region offset, take distance from the texel
	assign cx = 32'(qx) + 32'(drv.offx);
	assign cy = 32'(qy) + 32'(drv.offy);

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s3 <= cx_sb[14];
			ax_s3  <= (32'(cx_sb[13:0]) >= cx) ? (32'(cx_sb[13:0]) - cx)
				: (cx - 32'(cx_sb[13:0]));
			ay_s3  <= (32'(cy_sb) >= cy) ? (32'(cy_sb) - cy) : (cy - 32'(cy_sb));
		end
	end

	// Stage 4: scale by target size
	always_ff @(posedge clk) begin
		if (adv) begin
			out_s4 <= out_s3;
			px_s4  <= 47'(ax_s3) * 47'(drv.tw);
			py_s4  <= 47'(ay_s3) * 47'(drv.th);
		end
	end

	// Saturate where the quotient would pass 31 bits
	assign satx = px_s4 >= 47'({drv.rw, 15'b0});
	assign saty = py_s4 >= 47'({drv.rh, 15'b0});

	frdt_pdiv #(.DW(15), .QW(31), .SW(2)) u_div_ox (
		.clk, .arst_n, .en(adv), .in_v(v_s4),
		.rem0(px_s4[29:15]), .nlow({px_s4[14:0], 16'b0}), .den(drv.rw),
		.sb({out_s4, satx}),
		.out_v(ox_v), .quo(qox), .sb_o(ox_sb)
	);

	frdt_pdiv #(.DW(15), .QW(31), .SW(1)) u_div_oy (
		.clk, .arst_n, .en(adv), .in_v(v_s4),
		.rem0(py_s4[29:15]), .nlow({py_s4[14:0], 16'b0}), .den(drv.rh),
		.sb(saty),
		.out_v(oy_v), .quo(qoy), .sb_o(oy_sb)
	);

	// Stage 5: square the offsets
	assign ox = ox_sb[0] ? 31'h7FFFFFFF : qox;
	assign oy = oy_sb ? 31'h7FFFFFFF : qoy;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s5 <= ox_sb[1];
			sqx_s5 <= 62'(ox) * 62'(ox);
			sqy_s5 <= 62'(oy) * 62'(oy);
		end
	end

	// Stage 6: sum of squares
	always_ff @(posedge clk) begin
		if (adv) begin
			out_s6 <= out_s5;
			sum_s6 <= 63'(sqx_s5) + 63'(sqy_s5);
		end
	end

	frdt_isqrt #(.SW(1)) u_sqrt (
		.clk, .arst_n, .en(adv), .in_v(v_s6), .val(sum_s6), .sb(out_s6),
		.out_v(rt_v), .root(len), .sb_o(rt_out)
	);

	// Stage 7: distance past the inner radius, times 255
	assign excess = (len > 32'(drv.minr)) ? (len - 32'(drv.minr)) : '0;
	assign e_w    = {excess, 8'b0} - 40'(excess);

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s7 <= rt_out;
			e_s7   <= e_w;
			sat_s7 <= 43'(e_w) >= {drv.outer, 8'b0};
		end
	end

	frdt_pdiv #(.DW(35), .QW(8), .SW(2)) u_div_dens (
		.clk, .arst_n, .en(adv), .in_v(v_s7),
		.rem0(35'(e_s7[39:8])), .nlow(e_s7[7:0]), .den(drv.outer),
		.sb({out_s7, sat_s7}),
		.out_v(dn_v), .quo(qd), .sb_o(dn_sb)
	);

	// Output register
	always_ff @(posedge clk) begin
		if (adv) begin
			oout_q  <= dn_sb[1];
			odens_q <= dn_sb[1] ? 8'd0 : (dn_sb[0] ? 8'd255 : qd);
		end
	end

	assign result.valid       = ov_q;
	assign result.density     = odens_q;
	assign result.outside_map = oout_q;

endmodule

/* rtl/foveated_rate_density_texel.sv */
// Top level of the foveated variable-rate density texel generator.
// Takes one texel request per clock while setup is done and the queue has room,
// and returns one density byte per texel in request order. The back end is
// built on bit-per-stage pipelines: two 31-stage dividers in series (focus
// center, then scaled offset), a 32-stage square root and an 8-stage divider
// for the final ratio. A four-entry queue sits between the accepting front end
// and the compute back end, so requests can still be accepted while a result
// waits, until the queue is full. After reset and after every register write,
// a setup pass runs six divisions on one shared divider, with texel.ready low
// meanwhile.
module foveated_rate_density_texel import frdt_pkg::*; #(
	parameter int TEXEL_WIDTH  = TEXEL_WIDTH_DEF,
	parameter int TEXEL_HEIGHT = TEXEL_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	frdt_in_if.sink               texel,
	frdt_out_if.source            result,
	input  logic                  write_en,
	input  logic [REG_IDX_W-1:0]  reg_index,
	input  logic [REG_DATA_W-1:0] write_data
);

	cfg_derived_t drv;
	q_item_t      item;
	logic         item_valid;
	logic         item_pop;

	frdt_setup #(.TEXEL_WIDTH(TEXEL_WIDTH), .TEXEL_HEIGHT(TEXEL_HEIGHT)) u_setup (
		.clk, .arst_n, .write_en, .reg_index, .write_data, .drv
	);

	frdt_front u_front (
		.clk, .arst_n, .texel, .drv, .item, .item_valid, .item_pop
	);

	frdt_back u_back (
		.clk, .arst_n, .drv, .item, .item_valid, .item_pop, .result
	);

endmodule

/* rtl/frdt_checker.sv */
// Port-level checks of the density texel block, bound to the top level.
module frdt_checker (
	input logic        clk,
	input logic        arst_n,
	frdt_in_if.sink    texel,
	frdt_out_if.source result,
	input logic        write_en
);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid
			&& $stable(result.density) && $stable(result.outside_map))
		else $error("stalled result changed");

	// Texels beyond the map give zero density
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.outside_map |-> result.density == 8'd0)
		else $error("outside texel with nonzero density");

	// A register write restarts setup, so no transfer right after it
	a_setup_block: assert property (@(posedge clk) disable iff (!arst_n)
		write_en |=> !texel.ready)
		else $error("texel accepted during setup");

endmodule

bind foveated_rate_density_texel frdt_checker u_frdt_checker (
	.clk(clk), .arst_n(arst_n), .texel(texel), .result(result), .write_en(write_en)
);
